// ----- src/assert_macros.svh -----
// Assertion macros shared by the receiver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/sbusr_pkg.sv -----
// Types and constants for the serial frame receiver.
`timescale 1ns / 1ps

package sbusr_pkg;

    localparam logic [7:0] SYNC_BYTE    = 8'h0F;
    localparam logic [4:0] FRAME_LEN    = 5'd25;
    localparam logic [4:0] POS_LAST     = 5'd24;
    localparam logic [4:0] STORED_LEN   = 5'd23;
    localparam int         STORED_DEPTH = 23;
    localparam int         FLAG_AT      = 22;
    localparam int         DATA_BYTES   = 22;
    localparam int         DATA_BITS    = DATA_BYTES * 8;
    localparam int         CHAN_BITS    = 11;
    localparam logic [4:0] LAST_CH      = 5'd17;
    localparam logic [4:0] FIRST_DIG_CH = 5'd16;

    localparam int FLAG_DIG0_BIT     = 0;
    localparam int FLAG_DIG1_BIT     = 1;
    localparam int FLAG_LOST_BIT     = 2;
    localparam int FLAG_FAILSAFE_BIT = 3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FAILSAFE = 2'd1;
    localparam logic [1:0] STATUS_LOST     = 2'd2;

    localparam logic [1:0] CFG_GAP_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_DIGITAL_LOW  = 2'd1;
    localparam logic [1:0] CFG_DIGITAL_HIGH = 2'd2;

    localparam logic [15:0] GAP_TIMEOUT_RESET  = 16'd3500;
    localparam logic [10:0] DIGITAL_LOW_RESET  = 11'd173;
    localparam logic [10:0] DIGITAL_HIGH_RESET = 11'd1812;

    // Completed frame handed from the framer to the channel emitter.
    typedef struct packed {
        logic [DATA_BITS-1:0] data;
        logic [1:0]           digital;
        logic [1:0]           status;
        logic [31:0]          start_us;
    } frame_snap_t;

endpackage

// ----- src/sbusr_framer.sv -----
// Byte framer: input register, gap detection, byte position and frame buffer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbusr_framer
    import sbusr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] now_us,
    input  logic [15:0] gap_timeout_us,
    input  logic        emit_busy,
    output logic        snap_load,
    output frame_snap_t snap
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [31:0] in_now_reg;
    logic [4:0]  pos_reg;
    logic [4:0]  pos_next;
    logic [31:0] start_reg;
    logic [31:0] start_next;
    logic [7:0]  frame_mem [0:STORED_DEPTH-1];

    logic [31:0] diff;
    logic        gap_hit;
    logic [4:0]  pos_eff;
    logic        proc_block;
    logic        proc_fire;
    logic        wr_en;
    logic [4:0]  wr_addr;
    logic [7:0]  flags;
    logic [1:0]  status;

    // Hold the transaction in the input register while a frame completion
    // would collide with results still draining.
    assign proc_block = emit_busy && (pos_reg == POS_LAST);
    assign in_stall   = in_valid_reg && proc_block;
    assign proc_fire  = in_valid_reg && !proc_block;

    always_comb
    begin
        diff    = in_now_reg - start_reg;
        gap_hit = !diff[31] && (diff > {16'd0, gap_timeout_us});
        pos_eff = gap_hit ? 5'd0 : pos_reg;

        pos_next   = pos_reg;
        start_next = start_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_eff - 5'd1;
        snap_load  = 1'b0;

        if (proc_fire)
        begin
            pos_next = pos_eff;
            priority if (pos_eff == 5'd0 && in_byte_reg != SYNC_BYTE)
            begin
                // drop: no frame in progress
            end
            else if (pos_eff < FRAME_LEN)
            begin
                if (pos_eff == 5'd0)
                begin
                    start_next = in_now_reg;
                end
                pos_next  = pos_eff + 5'd1;
                wr_en     = (pos_eff >= 5'd1) && (pos_eff <= STORED_LEN);
                snap_load = (pos_eff == POS_LAST);
            end
            else
            begin
                // frame complete: ignore bytes until the next gap
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < DATA_BYTES; i++)
        begin
            snap.data[i*8 +: 8] = frame_mem[i];
        end
        flags = frame_mem[FLAG_AT];
        priority if (flags[FLAG_FAILSAFE_BIT])
        begin
            status = STATUS_FAILSAFE;
        end
        else if (flags[FLAG_LOST_BIT])
        begin
            status = STATUS_LOST;
        end
        else
        begin
            status = STATUS_OK;
        end
        snap.digital  = {flags[FLAG_DIG1_BIT], flags[FLAG_DIG0_BIT]};
        snap.status   = status;
        snap.start_us = (status == STATUS_OK) ? start_reg : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pos_reg      <= 5'd0;
            start_reg    <= 32'd0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            pos_reg   <= pos_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg <= rx_byte;
            in_now_reg  <= now_us;
        end
        if (wr_en)
        begin
            frame_mem[wr_addr] <= in_byte_reg;
        end
    end

    `ASSERT_IMPLIES(a_pos_range, clk, rst_n, 1'b1, pos_reg <= FRAME_LEN)
    `ASSERT_IMPLIES(a_load_when_idle, clk, rst_n, snap_load, !emit_busy)
    `ASSERT_NEXT(a_load_ends_frame, clk, rst_n, snap_load, pos_reg == FRAME_LEN)

endmodule

// ----- src/sbusr_emitter.sv -----
// Channel emitter: frame snapshot, channel counter and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbusr_emitter
    import sbusr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        snap_load,
    input  frame_snap_t snap,
    input  logic [10:0] digital_low_value,
    input  logic [10:0] digital_high_value,
    output logic        emit_busy,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  channel_index,
    output logic [10:0] channel_value,
    output logic [1:0]  frame_status,
    output logic [31:0] frame_start_us,
    output logic        last_channel
);

    frame_snap_t snap_reg;
    logic        busy_reg;
    logic        busy_next;
    logic [4:0]  ch_reg;
    logic [4:0]  ch_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [4:0]  index_reg;
    logic [10:0] value_reg;
    logic [1:0]  status_reg;
    logic [31:0] start_reg;
    logic        last_reg;

    logic        out_free;
    logic        emit;
    logic [7:0]  ch_off;
    logic [10:0] value_next;

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = busy_reg && out_free;
    assign ch_off   = 8'(ch_reg[3:0]) * 8'(CHAN_BITS);

    always_comb
    begin
        if (ch_reg < FIRST_DIG_CH)
        begin
            value_next = snap_reg.data[ch_off +: CHAN_BITS];
        end
        else
        begin
            value_next = snap_reg.digital[ch_reg[0]] ? digital_high_value
                                                     : digital_low_value;
        end

        busy_next      = busy_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = emit;
        end
        if (emit)
        begin
            ch_next = ch_reg + 5'd1;
            if (ch_reg == LAST_CH)
            begin
                busy_next = 1'b0;
            end
        end
        if (snap_load)
        begin
            busy_next = 1'b1;
            ch_next   = 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            ch_reg        <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            snap_reg <= snap;
        end
        if (emit)
        begin
            index_reg  <= ch_reg;
            value_reg  <= value_next;
            status_reg <= snap_reg.status;
            start_reg  <= snap_reg.start_us;
            last_reg   <= (ch_reg == LAST_CH);
        end
    end

    assign emit_busy      = busy_reg;
    assign out_valid      = out_valid_reg;
    assign channel_index  = index_reg;
    assign channel_value  = value_reg;
    assign frame_status   = status_reg;
    assign frame_start_us = start_reg;
    assign last_channel   = last_reg;

    `ASSERT_IMPLIES(a_ch_range, clk, rst_n, busy_reg, ch_reg <= LAST_CH)
    `ASSERT_IMPLIES(a_last_is_ch17, clk, rst_n, out_valid_reg && last_reg, index_reg == LAST_CH)
    `ASSERT_NEXT(a_drain_ends, clk, rst_n, emit && ch_reg == LAST_CH && !snap_load, !busy_reg)

endmodule

// ----- src/sbus_frame_receiver_core.sv -----
// Top level of the serial frame receiver: configuration registers and datapath.
`timescale 1ns / 1ps

// Receives one serial byte with its microsecond timestamp per transaction and
// takes one byte every clock cycle that the input is not stalled. The 25th
// byte of a frame loads a snapshot into the channel emitter, which delivers
// 18 channel results, one per cycle that the output is not stalled, through
// its snapshot register and output register. The input stalls only when a
// byte held at the last frame position is waiting while the previous frame's
// results are still draining; the emitter's single frame snapshot sets that
// limit. Configuration writes are always taken (cfg_ready is tied high);
// indexes past the register list are ignored.
module sbus_frame_receiver_core
    import sbusr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] now_us,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  channel_index,
    output logic [10:0] channel_value,
    output logic [1:0]  frame_status,
    output logic [31:0] frame_start_us,
    output logic        last_channel,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] gap_timeout_reg;
    logic [10:0] dig_low_reg;
    logic [10:0] dig_high_reg;
    logic        emit_busy;
    logic        snap_load;
    frame_snap_t snap;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_timeout_reg <= GAP_TIMEOUT_RESET;
            dig_low_reg     <= DIGITAL_LOW_RESET;
            dig_high_reg    <= DIGITAL_HIGH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GAP_TIMEOUT:  gap_timeout_reg <= cfg_data;
                CFG_DIGITAL_LOW:  dig_low_reg     <= cfg_data[10:0];
                CFG_DIGITAL_HIGH: dig_high_reg    <= cfg_data[10:0];
                default:
                begin
                    // drop writes past the register list
                end
            endcase
        end
    end

    sbusr_framer u_framer (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .now_us         (now_us),
        .gap_timeout_us (gap_timeout_reg),
        .emit_busy      (emit_busy),
        .snap_load      (snap_load),
        .snap           (snap)
    );

    sbusr_emitter u_emitter (
        .clk                (clk),
        .rst_n              (rst_n),
        .snap_load          (snap_load),
        .snap               (snap),
        .digital_low_value  (dig_low_reg),
        .digital_high_value (dig_high_reg),
        .emit_busy          (emit_busy),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .channel_index      (channel_index),
        .channel_value      (channel_value),
        .frame_status       (frame_status),
        .frame_start_us     (frame_start_us),
        .last_channel       (last_channel)
    );

endmodule

// ----- verif/sbus_frame_receiver_core_tb.sv -----
// Self-checking testbench for the serial frame receiver core.
`timescale 1ns / 1ps

module sbus_frame_receiver_core_tb;
    import sbusr_pkg::*;

    localparam int         IDLE_PCT    = 37;
    localparam int         CYCLE_LIMIT = 300000;
    localparam int         SETTLE_CYC  = 8;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;

    typedef struct {
        logic [7:0]  data;
        logic [31:0] stamp;
    } rx_beat_t;

    typedef struct {
        logic [4:0]  index;
        logic [10:0] value;
        logic [1:0]  status;
        logic [31:0] start_us;
        logic        last;
    } channel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'd0;
    logic [31:0] now_us = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  channel_index;
    logic [10:0] channel_value;
    logic [1:0]  frame_status;
    logic [31:0] frame_start_us;
    logic        last_channel;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'd0;

    // byte stream waiting for the driver and channel results still owed
    rx_beat_t pending_bytes[$];
    channel_t expected_channels[$];
    rx_beat_t next_beat;

    // shadow of the receiver: registers and framing state
    logic [15:0] gap_us = GAP_TIMEOUT_RESET;
    logic [10:0] dig_low = DIGITAL_LOW_RESET;
    logic [10:0] dig_high = DIGITAL_HIGH_RESET;
    logic [7:0]  frame_store[STORED_DEPTH];
    int          frame_pos = 0;
    logic [31:0] sync_time_us = 32'd0;

    logic [31:0] gen_t0;
    bit          steady = 1'b0;
    int          frame_bytes_sent = 0;
    int          frames_done = 0;
    int          channels_checked = 0;
    int          error_cnt = 0;
    int          cycle_cnt = 0;

    sbus_frame_receiver_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .now_us         (now_us),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .channel_index  (channel_index),
        .channel_value  (channel_value),
        .frame_status   (frame_status),
        .frame_start_us (frame_start_us),
        .last_channel   (last_channel),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #4 clk = ~clk;

    // Advance the shadow framer by one byte; queue 18 channels on frame completion.
    task automatic decode_byte(input logic [7:0] b, input logic [31:0] t);
        logic [31:0]          since;
        logic [7:0]           flags;
        logic [1:0]           status;
        logic [DATA_BITS-1:0] data_bits;
        channel_t             ch;
        int                   k;
        since = t - sync_time_us;
        if (!since[31] && since > {16'd0, gap_us})
            frame_pos = 0;
        if (frame_pos == 0)
        begin
            if (b != SYNC_BYTE)
                return;
            sync_time_us = t;
        end
        if (frame_pos >= FRAME_LEN)
            return;
        if (frame_pos >= 1 && frame_pos <= STORED_LEN)
            frame_store[frame_pos - 1] = b;
        frame_pos++;
        if (frame_pos < FRAME_LEN)
            return;

        flags = frame_store[FLAG_AT];
        if (flags[FLAG_FAILSAFE_BIT])
            status = STATUS_FAILSAFE;
        else if (flags[FLAG_LOST_BIT])
            status = STATUS_LOST;
        else
            status = STATUS_OK;
        for (k = 0; k < DATA_BYTES; k++)
            data_bits[8 * k +: 8] = frame_store[k];
        for (k = 0; k <= LAST_CH; k++)
        begin
            ch.index = k[4:0];
            if (k < FIRST_DIG_CH)
                ch.value = data_bits[CHAN_BITS * k +: CHAN_BITS];
            else
                ch.value = flags[k - FIRST_DIG_CH] ? dig_high : dig_low;
            ch.status = status;
            ch.start_us = (status == STATUS_OK) ? sync_time_us : 32'd0;
            ch.last = (k == LAST_CH);
            expected_channels.push_back(ch);
        end
        frames_done++;
    endtask

    function void compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            error_cnt++;
        end
    endfunction

    task automatic check_channel;
        channel_t ch;
        if (expected_channels.size() == 0)
        begin
            $error("unexpected channel result, channel_index %0d", channel_index);
            error_cnt++;
            return;
        end
        ch = expected_channels.pop_front();
        compare_field("channel_index", 32'(ch.index), 32'(channel_index));
        compare_field("channel_value", 32'(ch.value), 32'(channel_value));
        compare_field("frame_status", 32'(ch.status), 32'(frame_status));
        compare_field("frame_start_us", ch.start_us, frame_start_us);
        compare_field("last_channel", 32'(ch.last), 32'(last_channel));
        channels_checked++;
    endtask

    // Byte driver: hold the payload while stalled, idle at random.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (pending_bytes.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                next_beat = pending_bytes.pop_front();
                in_valid <= 1'b1;
                rx_byte <= next_beat.data;
                now_us <= next_beat.stamp;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);

    // Monitor: predict on each accepted byte, then check any accepted channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                decode_byte(rx_byte, now_us);
            if (out_valid && !out_stall)
                check_channel();
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d channels outstanding",
                     cycle_cnt, expected_channels.size());
            $display("sbus_frame_receiver_core verification failed");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic [31:0] t);
        rx_beat_t beat;
        beat.data = b;
        beat.stamp = t;
        pending_bytes.push_back(beat);
    endtask

    // Sync after a gap, then n_bytes - 1 frame bytes spread within the timeout.
    task automatic push_frame(input int n_bytes);
        logic [31:0] base;
        logic [31:0] stamp;
        logic [7:0]  flags;
        logic [7:0]  val;
        int          fill;
        int          k;
        bit          tight;
        if ($urandom_range(9) == 0)
            base = gen_t0 + gap_us + 32'd1 + $urandom_range(32'h3FFF_FFFF);
        else
            base = gen_t0 + gap_us + 32'd1 + $urandom_range(2000);
        gen_t0 = base;
        tight = ($urandom_range(4) == 0);
        fill = $urandom_range(9);
        flags = 8'($urandom);
        case ($urandom_range(3))
            0: flags[FLAG_FAILSAFE_BIT:FLAG_LOST_BIT] = 2'b00;
            1: flags[FLAG_FAILSAFE_BIT:FLAG_LOST_BIT] = 2'b01;
            default: ;
        endcase
        stamp = base;
        queue_byte(SYNC_BYTE, base);
        for (k = 1; k < n_bytes; k++)
        begin
            // tight frames land the end byte exactly on the timeout
            if (tight)
                stamp = base + (gap_us * k) / 24;
            else
                stamp = stamp + $urandom_range(gap_us / 24);
            if (k <= DATA_BYTES)
                val = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
            else if (k == DATA_BYTES + 1)
                val = flags;
            else
                val = 8'($urandom);
            // a timestamp behind the sync reads as negative and must not reset
            if ($urandom_range(24) == 0)
                queue_byte(val, base - $urandom_range(32'h8000_0000, 1));
            else
                queue_byte(val, stamp);
        end
        frame_bytes_sent += n_bytes;
    endtask

    task automatic push_noise(input int n);
        logic [7:0] b;
        int         k;
        for (k = 0; k < n; k++)
        begin
            b = 8'($urandom);
            if (b == SYNC_BYTE)
                b = b ^ 8'h10;
            if ($urandom_range(1) == 0)
                queue_byte(b, $urandom);
            else
                queue_byte(b, gen_t0 + gap_us + 32'd1 + $urandom_range(500));
        end
    endtask

    task automatic push_traffic(input int goal);
        int stop_at;
        int pick;
        stop_at = frame_bytes_sent + goal;
        while (frame_bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                push_frame(FRAME_LEN);
                // bytes after a full frame and before the gap are dropped
                repeat ($urandom_range(2))
                    queue_byte(8'($urandom), gen_t0 + $urandom_range(gap_us));
            end
            else if (pick < 85)
                push_frame($urandom_range(POS_LAST, 1));
            else
                push_noise($urandom_range(3, 1));
        end
    endtask

    task automatic settle;
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_channels.size() != 0);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GAP_TIMEOUT:  gap_us = value;
            CFG_DIGITAL_LOW:  dig_low = value[10:0];
            CFG_DIGITAL_HIGH: dig_high = value[10:0];
            default: ;
        endcase
    endtask

    initial
    begin
        int k;
        for (k = 0; k < STORED_DEPTH; k++)
            frame_store[k] = 8'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frame across the time wrap, at reset register values.
        gen_t0 = 32'hFFFF_FC00;
        queue_byte(8'h00, gen_t0 - 32'd10);
        queue_byte(SYNC_BYTE, gen_t0);
        for (k = 0; k < DATA_BYTES; k++)
            queue_byte((k == 1) ? SYNC_BYTE : (k < 11) ? 8'hFF : 8'h00,
                       (k == 5) ? gen_t0 - 32'h8000_0000 : gen_t0 + 100 * (k + 1));
        // failsafe and signal loss together, both digital flags set
        queue_byte(8'h0F, gen_t0 + 32'd2300);
        queue_byte(8'hA5, gen_t0 + GAP_TIMEOUT_RESET);
        queue_byte(SYNC_BYTE, gen_t0 + GAP_TIMEOUT_RESET);
        queue_byte(8'h33, gen_t0 + GAP_TIMEOUT_RESET + 32'd1);
        frame_bytes_sent += FRAME_LEN;
        push_traffic(80);
        settle();

        // Zero timeout: frames only hold together at the sync timestamp or behind it.
        write_reg(CFG_GAP_TIMEOUT, 16'd0);
        write_reg(CFG_DIGITAL_LOW, 16'h0000);
        write_reg(CFG_DIGITAL_HIGH, 16'hFFFF);
        push_traffic(80);
        settle();

        write_reg(CFG_GAP_TIMEOUT, 16'hFFFF);
        write_reg(CFG_DIGITAL_LOW, 16'h07FF);
        write_reg(CFG_DIGITAL_HIGH, 16'hF800);
        write_reg(CFG_UNUSED, 16'(($urandom)));
        push_traffic(80);
        settle();

        write_reg(CFG_GAP_TIMEOUT, 16'($urandom_range(8000, 24)));
        write_reg(CFG_DIGITAL_LOW, 16'($urandom));
        write_reg(CFG_DIGITAL_HIGH, 16'($urandom));
        steady = 1'b1;
        push_traffic(40);
        settle();
        steady = 1'b0;
        push_traffic(40);
        settle();

        $display("%0d frame bytes sent, %0d frames decoded, %0d channels checked",
                 frame_bytes_sent, frames_done, channels_checked);
        $display("register settings: reset, zero timeout, full timeout, random");
        if (error_cnt == 0)
            $display("sbus_frame_receiver_core verification clean");
        else
            $display("sbus_frame_receiver_core verification failed");
        $finish;
    end

endmodule
